### rtl/core/integer_matrix_multiply_macros.svh
// Assertion helpers for the integer matrix multiplier.
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

`ifndef ASSERT_OFF
`define IMM_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("assertion failed");
`define IMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define IMM_ASSERT_SAME(lbl, clk, rstn, ante, cons)
`define IMM_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

### rtl/core/imm_pkg.sv
`default_nettype none

package imm_pkg;

	localparam int MAX_DIM = 8;
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int ADDR_W  = 2 * IDX_W;
	localparam int DEPTH   = MAX_DIM * MAX_DIM;
	localparam int DIM_W   = 4;
	localparam int DATA_W  = 32;

	localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(8);

	localparam logic [1:0] OP_LOAD_A  = 2'd0;
	localparam logic [1:0] OP_LOAD_B  = 2'd1;
	localparam logic [1:0] OP_COMPUTE = 2'd2;

	localparam logic [1:0] REG_ROWS_A    = 2'd0;
	localparam logic [1:0] REG_INNER_DIM = 2'd1;
	localparam logic [1:0] REG_COLS_B    = 2'd2;

	typedef struct packed {
		logic valid;
		logic first;
	} mac_ctl_t;

	function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (v > DIM_W'(MAX_DIM)) begin
			r = DIM_W'(MAX_DIM);
		end else begin
			r = v;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/imm_mac.sv
`default_nettype none

module imm_mac (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire imm_pkg::mac_ctl_t         ctl,
	input  wire  [imm_pkg::DATA_W-1:0]     a,
	input  wire  [imm_pkg::DATA_W-1:0]     b,
	output logic [imm_pkg::DATA_W-1:0]     acc,
	output logic                           busy
);
	import imm_pkg::*;

	logic [DATA_W-1:0]   full_prod;
	logic [DATA_W-1:0]   product_s1;
	mac_ctl_t            ctl_s1;
	logic [DATA_W-1:0]   acc_q;

	assign full_prod = a * b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		product_s1 <= full_prod;
		if (ctl_s1.valid) begin
			if (ctl_s1.first) begin
				acc_q <= product_s1;
			end else begin
				acc_q <= acc_q + product_s1;
			end
		end
	end

	assign acc  = acc_q;
	assign busy = ctl_s1.valid;

endmodule

`default_nettype wire

### rtl/core/integer_matrix_multiply.sv
// Signed 32-bit integer matrix multiplier. Load transactions (op 0 for A, op 1 for B) write
// one element each and are taken one per cycle while no compute runs; loads outside the
// configured size are dropped. A compute transaction (op 2) produces rows_a * cols_b results
// in row-major order, the final one marked by last. All products go through one shared
// multiply-accumulate unit fed by registered reads of the two element memories, one term per
// cycle, and in_stall stays high while a compute runs, through any output stall. Register
// values of 0 act as 1 and values above 8 act as 8. The memories need no clearing after
// reset, but every element used by a compute must have been loaded first.
`default_nettype none

`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            cfg_we,
	input  wire  [1:0]                     cfg_index,
	input  wire  [imm_pkg::DIM_W-1:0]      cfg_data,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  wire  [1:0]                     op,
	input  wire  [2:0]                     row,
	input  wire  [2:0]                     col,
	input  wire  signed [31:0]             elem_value,
	output logic                           out_valid,
	input  wire                            out_stall,
	output logic [2:0]                     out_row,
	output logic [2:0]                     out_col,
	output logic signed [31:0]             product_value,
	output logic                           last
);
	import imm_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [DIM_W-1:0]  rows_a_q;
	logic [DIM_W-1:0]  inner_dim_q;
	logic [DIM_W-1:0]  cols_b_q;
	logic [DIM_W-1:0]  nr;
	logic [DIM_W-1:0]  nk;
	logic [DIM_W-1:0]  nc;
	logic [IDX_W-1:0]  nr_m1;
	logic [IDX_W-1:0]  nk_m1;
	logic [IDX_W-1:0]  nc_m1;

	logic [1:0]        state_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;

	logic [DATA_W-1:0] mem_a [DEPTH];
	logic [DATA_W-1:0] mem_b [DEPTH];
	logic [DATA_W-1:0] rd_a_q;
	logic [DATA_W-1:0] rd_b_q;
	mac_ctl_t          iss_ctl;
	mac_ctl_t          rd_ctl_q;
	logic [DATA_W-1:0] acc;
	logic              mac_busy;

	logic              in_acc;
	logic              cmp_start;
	logic              wr_a;
	logic              wr_b;
	logic [ADDR_W-1:0] wr_addr;
	logic              pipe_empty;
	logic              out_load;
	logic              last_elem;

	logic              out_valid_q;
	logic [2:0]        out_row_q;
	logic [2:0]        out_col_q;
	logic [DATA_W-1:0] out_value_q;
	logic              out_last_q;

	assign nr    = eff_dim(rows_a_q);
	assign nk    = eff_dim(inner_dim_q);
	assign nc    = eff_dim(cols_b_q);
	assign nr_m1 = IDX_W'(nr - DIM_W'(1));
	assign nk_m1 = IDX_W'(nk - DIM_W'(1));
	assign nc_m1 = IDX_W'(nc - DIM_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_a_q    <= DIM_RESET;
			inner_dim_q <= DIM_RESET;
			cols_b_q    <= DIM_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROWS_A:    rows_a_q    <= cfg_data;
				REG_INNER_DIM: inner_dim_q <= cfg_data;
				REG_COLS_B:    cols_b_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign cmp_start = in_acc && (op == OP_COMPUTE);
	assign wr_addr   = {IDX_W'(row), IDX_W'(col)};
	assign wr_a      = in_acc && (op == OP_LOAD_A)
		&& ({1'b0, row} < nr) && ({1'b0, col} < nk);
	assign wr_b      = in_acc && (op == OP_LOAD_B)
		&& ({1'b0, row} < nk) && ({1'b0, col} < nc);

	always_ff @(posedge clk) begin
		if (wr_a) begin
			mem_a[wr_addr] <= elem_value;
		end
		rd_a_q <= mem_a[{i_q, k_q}];
	end

	always_ff @(posedge clk) begin
		if (wr_b) begin
			mem_b[wr_addr] <= elem_value;
		end
		rd_b_q <= mem_b[{k_q, j_q}];
	end

	assign iss_ctl = '{valid: (state_q == ST_ISSUE), first: (k_q == '0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ctl_q <= '0;
		end else begin
			rd_ctl_q <= iss_ctl;
		end
	end

	imm_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (rd_ctl_q),
		.a      (rd_a_q),
		.b      (rd_b_q),
		.acc    (acc),
		.busy   (mac_busy)
	);

	assign pipe_empty = !rd_ctl_q.valid && !mac_busy;
	assign out_load   = (state_q == ST_DRAIN) && pipe_empty && (!out_valid_q || !out_stall);
	assign last_elem  = (i_q == nr_m1) && (j_q == nc_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmp_start) begin
						i_q     <= '0;
						j_q     <= '0;
						k_q     <= '0;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (k_q == nk_m1) begin
						k_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (out_load) begin
						if (last_elem) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_q == nc_m1) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
							state_q <= ST_ISSUE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= 3'(i_q);
			out_col_q   <= 3'(j_q);
			out_value_q <= acc;
			out_last_q  <= last_elem;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign product_value = out_value_q;
	assign last          = out_last_q;

	`IMM_ASSERT_SAME(a_load_pipe_empty, clk, arst_n, out_load, !rd_ctl_q.valid && !mac_busy)
	`IMM_ASSERT_NEXT(a_compute_start, clk, arst_n, cmp_start, state_q == ST_ISSUE)
	`IMM_ASSERT_NEXT(a_compute_origin, clk, arst_n, cmp_start, {i_q, j_q, k_q} == '0)
	`IMM_ASSERT_NEXT(a_last_to_idle, clk, arst_n, out_load && last_elem, state_q == ST_IDLE)
	`IMM_ASSERT_NEXT(a_last_flag, clk, arst_n, out_load && last_elem, out_valid_q && out_last_q)
	`IMM_ASSERT_SAME(a_no_write_busy, clk, arst_n, state_q != ST_IDLE, !wr_a && !wr_b)

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import imm_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        last;
	} product_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [2:0]  row;
		logic [2:0]  col;
		logic [31:0] value;
		logic        typed;
		logic [31:0] want;
	} step_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [DIM_W-1:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic [2:0] row;
	logic [2:0] col;
	logic signed [31:0] elem_value;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] out_row;
	logic [2:0] out_col;
	logic signed [31:0] product_value;
	logic last;

	integer_matrix_multiply u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.op            (op),
		.row           (row),
		.col           (col),
		.elem_value    (elem_value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_row       (out_row),
		.out_col       (out_col),
		.product_value (product_value),
		.last          (last)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	logic [31:0] a_mem [64];
	logic [31:0] b_mem [64];
	bit a_set [64];
	bit b_set [64];
	logic [DIM_W-1:0] rows_cfg = DIM_RESET;
	logic [DIM_W-1:0] inner_cfg = DIM_RESET;
	logic [DIM_W-1:0] cols_cfg = DIM_RESET;

	product_t product_queue [$];
	product_t got_product;
	product_t want_product;
	int errors = 0;
	int items = 0;
	int sent = 0;
	int gap_odds = 1;
	int stall_odds = 1;
	int stall_left = 0;
	int cycle_count = 0;
	bit quiet = 1'b0;

	step_t script [23] = '{
		'{OP_LOAD_A,  3'd0, 3'd0, 32'h7fffffff, 1'b0, 32'h0},
		'{OP_LOAD_B,  3'd0, 3'd0, 32'h7fffffff, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'h00000001},
		'{OP_LOAD_A,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
		'{OP_LOAD_B,  3'd0, 3'd0, 32'h80000000, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd7, 3'd7, 32'hffffffff, 1'b1, 32'h00000000},
		'{OP_LOAD_A,  3'd7, 3'd7, 32'h12345678, 1'b0, 32'h0},
		'{OP_LOAD_A,  3'd1, 3'd0, 32'h00000005, 1'b0, 32'h0},
		'{OP_LOAD_B,  3'd0, 3'd1, 32'h00000005, 1'b0, 32'h0},
		'{OP_LOAD_B,  3'd1, 3'd0, 32'h00000005, 1'b0, 32'h0},
		'{OP_UNUSED,  3'd7, 3'd7, 32'hffffffff, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'h00000000},
		'{OP_LOAD_A,  3'd0, 3'd0, 32'hffffffff, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'h80000000},
		'{OP_LOAD_B,  3'd0, 3'd0, 32'hffffffff, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'h00000001},
		'{OP_LOAD_A,  3'd0, 3'd0, 32'h00000000, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'h00000000},
		'{OP_LOAD_A,  3'd0, 3'd0, 32'h00000003, 1'b0, 32'h0},
		'{OP_LOAD_B,  3'd0, 3'd0, 32'hfffffffb, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'hfffffff1},
		'{OP_UNUSED,  3'd0, 3'd0, 32'h00000000, 1'b0, 32'h0},
		'{OP_COMPUTE, 3'd0, 3'd0, 32'h00000000, 1'b1, 32'hfffffff1}
	};

	function automatic int unsigned span(input logic [DIM_W-1:0] v);
		if (v == '0) begin
			return 1;
		end
		if (v > DIM_W'(MAX_DIM)) begin
			return MAX_DIM;
		end
		return int'(v);
	endfunction

	// Apply one transaction to the shadow stores and the product queue; returns 1 for an in-range load or any compute.
	function automatic bit predict_products(input logic [1:0] o, input logic [2:0] r,
			input logic [2:0] c, input logic [31:0] v, input bit keep);
		int unsigned nr;
		int unsigned nk;
		int unsigned nc;
		logic [31:0] acc;
		logic [31:0] term;
		product_t p;
		nr = span(rows_cfg);
		nk = span(inner_cfg);
		nc = span(cols_cfg);
		case (o)
			OP_LOAD_A: begin
				if (r < nr && c < nk) begin
					a_mem[{r, c}] = v;
					a_set[{r, c}] = 1'b1;
					return 1'b1;
				end
			end
			OP_LOAD_B: begin
				if (r < nk && c < nc) begin
					b_mem[{r, c}] = v;
					b_set[{r, c}] = 1'b1;
					return 1'b1;
				end
			end
			OP_COMPUTE: begin
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = '0;
						for (int k = 0; k < nk; k++) begin
							term = a_mem[i * MAX_DIM + k] * b_mem[k * MAX_DIM + j];
							acc = acc + term;
						end
						p.row = 3'(i);
						p.col = 3'(j);
						p.value = acc;
						p.last = (i == nr - 1) && (j == nc - 1);
						if (keep) begin
							product_queue.push_back(p);
						end
					end
				end
				return 1'b1;
			end
			default: begin
			end
		endcase
		return 1'b0;
	endfunction

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 11))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return 32'hffffffff;
			3: return 32'h00000000;
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] random_dim();
		if ($urandom_range(0, 3) == 0) begin
			return DIM_W'($urandom_range(0, 15));
		end
		return DIM_W'($urandom_range(1, 4));
	endfunction

	function automatic void compare_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			errors++;
		end
	endfunction

	task automatic send_item(input logic [1:0] o, input logic [2:0] r, input logic [2:0] c,
			input logic [31:0] v, input bit keep);
		int gap;
		sent++;
		if (sent % 32 == 0) begin
			gap_odds = $urandom_range(0, 3);
		end
		if (!quiet && gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0) begin
			in_valid <= 1'b0;
			gap = $urandom_range(1, 9);
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		row <= r;
		col <= c;
		elem_value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (predict_products(o, r, c, v, keep)) begin
			items++;
		end
		quiet = (items >= 330);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (product_queue.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic set_dims(input logic [DIM_W-1:0] nr, input logic [DIM_W-1:0] nk,
			input logic [DIM_W-1:0] nc);
		cfg_we <= 1'b1;
		cfg_index <= REG_ROWS_A;
		cfg_data <= nr;
		@(posedge clk);
		cfg_index <= REG_INNER_DIM;
		cfg_data <= nk;
		@(posedge clk);
		cfg_index <= REG_COLS_B;
		cfg_data <= nc;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_cfg = nr;
		inner_cfg = nk;
		cols_cfg = nc;
	endtask

	task automatic random_load();
		logic [1:0] o;
		logic [2:0] r;
		logic [2:0] c;
		int pick;
		pick = $urandom_range(0, 19);
		o = (pick < 9) ? OP_LOAD_A : (pick < 18) ? OP_LOAD_B : OP_UNUSED;
		if (o == OP_LOAD_A) begin
			r = 3'($urandom_range(0, span(rows_cfg) - 1));
			c = 3'($urandom_range(0, span(inner_cfg) - 1));
		end else begin
			r = 3'($urandom_range(0, span(inner_cfg) - 1));
			c = 3'($urandom_range(0, span(cols_cfg) - 1));
		end
		if (o == OP_UNUSED || $urandom_range(0, 7) == 0) begin
			r = 3'($urandom());
			c = 3'($urandom());
		end
		send_item(o, r, c, pick_value(), 1'b1);
	endtask

	// Load every element that the next compute reads and that has not been written yet.
	task automatic fill_missing();
		int unsigned nr;
		int unsigned nk;
		int unsigned nc;
		nr = span(rows_cfg);
		nk = span(inner_cfg);
		nc = span(cols_cfg);
		for (int i = 0; i < nr; i++) begin
			for (int k = 0; k < nk; k++) begin
				if (!a_set[i * MAX_DIM + k]) begin
					send_item(OP_LOAD_A, 3'(i), 3'(k), pick_value(), 1'b1);
				end
			end
		end
		for (int k = 0; k < nk; k++) begin
			for (int j = 0; j < nc; j++) begin
				if (!b_set[k * MAX_DIM + j]) begin
					send_item(OP_LOAD_B, 3'(k), 3'(j), pick_value(), 1'b1);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_product = '{out_row, out_col, product_value, last};
			if (product_queue.size() == 0) begin
				$display("%0t: unexpected result row %0d col %0d value %0h", $time,
					out_row, out_col, product_value);
				errors++;
			end else begin
				want_product = product_queue.pop_front();
				compare_field("out_row", 32'(want_product.row), 32'(got_product.row));
				compare_field("out_col", 32'(want_product.col), 32'(got_product.col));
				compare_field("product_value", want_product.value, got_product.value);
				compare_field("last", 32'(want_product.last), 32'(got_product.last));
			end
		end
		cycle_count++;
		if (cycle_count % 150 == 0) begin
			stall_odds = $urandom_range(0, 3);
		end
		if (stall_left == 0 && stall_odds != 0 && $urandom_range(0, 3 * stall_odds) == 0) begin
			stall_left = $urandom_range(1, 9);
		end
		if (quiet || !arst_n) begin
			stall_left = 0;
		end
		out_stall <= (stall_left != 0);
		if (stall_left != 0) begin
			stall_left--;
		end
	end

	initial begin
		int phase;
		int rounds;
		int loads;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_ROWS_A;
		cfg_data <= '0;
		in_valid <= 1'b0;
		op <= OP_LOAD_A;
		row <= '0;
		col <= '0;
		elem_value <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero dimensions act as a single element
		set_dims('0, '0, '0);
		foreach (script[n]) begin
			send_item(script[n].op, script[n].row, script[n].col, script[n].value,
				!script[n].typed);
			if (script[n].typed) begin
				product_queue.push_back('{3'd0, 3'd0, script[n].want, 1'b1});
			end
		end
		wait_drained();

		items = 0;
		phase = 0;
		while (items < 400) begin
			case (phase)
				0: set_dims(4'd15, 4'd15, 4'd15);
				1: set_dims(4'd8, 4'd8, 4'd8);
				2: set_dims(4'd1, 4'd8, 4'd1);
				3: set_dims(4'd8, 4'd1, 4'd8);
				default: set_dims(random_dim(), random_dim(), random_dim());
			endcase
			rounds = $urandom_range(1, 3);
			repeat (rounds) begin
				loads = $urandom_range(3, 20);
				repeat (loads) random_load();
				fill_missing();
				send_item(OP_COMPUTE, 3'($urandom()), 3'($urandom()), pick_value(), 1'b1);
			end
			wait_drained();
			phase++;
		end

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl/core
rtl/core/imm_pkg.sv
rtl/core/imm_mac.sv
rtl/core/integer_matrix_multiply.sv
tb/tb_top.sv
